// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

	localparam int DEFAULT_CAPACITY = 32;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic ACTION_INSERT = 1'b0;
	localparam logic ACTION_REMOVE = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] max_value;
		logic [1:0]         status;
		logic [5:0]         entries;
	} rsp_item_t;

endpackage

// ===== rtl/core/mhpq_heap_ram.sv =====
// One write port, two registered read ports.
module mhpq_heap_ram #(
	parameter int DEPTH = mhpq_pkg::DEFAULT_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic signed [31:0] wr_data,
	input  logic [AW-1:0]      rd_addr_a,
	input  logic [AW-1:0]      rd_addr_b,
	output logic signed [31:0] rd_data_a,
	output logic signed [31:0] rd_data_b
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== rtl/core/max_heap_priority_queue_core.sv =====
// Bounded binary max-heap of signed 32-bit values.
// Request channel (req_valid/req_ready/req): action 0 inserts req.value,
// action 1 removes the largest value held. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one item per request, carrying the
// removed maximum (zero otherwise), a status (ok, full, empty) and the
// number of entries held after the request.
// The heap lives in one synchronous RAM with one write and two read ports.
// The moving value is held in a register; each level writes the hole once.
// Full and empty requests go straight to the done state. An insert reads the
// parent of the hole and compares it, pulling a smaller parent down and
// climbing, and writes the value at the root or below a parent that is not
// smaller. A remove reads the root and the last entry; it ends there when it
// empties the heap, else per level it reads both children and compares them,
// moving a larger child up until the value lands on a slot without children
// or stops above them. req_ready returns on the edge that loads the response
// item; one request is worked at a time.
// The response sits in an output register; a new request is taken while
// it waits, and a stalled receiver only stops the block when the next
// result is ready to be written over it.
// Reset clears the entry count and handshake state; the RAM is not cleared.
module max_heap_priority_queue_core #(
	parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mhpq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output mhpq_pkg::rsp_item_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_UP_RD   = 3'd1;
	localparam logic [2:0] ST_UP_CMP  = 3'd2;
	localparam logic [2:0] ST_DN_LOAD = 3'd3;
	localparam logic [2:0] ST_DN_RD   = 3'd4;
	localparam logic [2:0] ST_DN_CMP  = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;
	localparam logic [2:0] ST_DN_WAIT = 3'd7;

	logic [2:0]         state_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] max_q;
	logic [1:0]         status_q;
	logic               rsp_valid_q;
	mhpq_pkg::rsp_item_t rsp_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic [AW-1:0]      rd_addr_a;
	logic [AW-1:0]      rd_addr_b;
	logic signed [31:0] rd_data_a;
	logic signed [31:0] rd_data_b;

	logic [XW-1:0]      left_w;
	logic [XW-1:0]      right_w;
	logic [XW-1:0]      count_w;
	logic [AW-1:0]      parent;
	logic               left_ok;
	logic               right_ok;
	logic               pick_l;
	logic               pick_r;
	logic signed [31:0] best_l;
	logic               accept;
	logic               rsp_free;

	mhpq_heap_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Child and parent slots of the hole.
	assign left_w   = {1'b0, idx_q, 1'b1};
	assign right_w  = left_w + XW'(1);
	assign count_w  = XW'(count_q);
	assign parent   = AW'((idx_q - AW'(1)) >> 1);
	assign left_ok  = left_w < count_w;
	assign right_ok = right_w < count_w;

	// Left child wins ties; a child moves up only when strictly greater.
	assign pick_l = rd_data_a > val_q;
	assign best_l = pick_l ? rd_data_a : val_q;
	assign pick_r = right_ok && (rd_data_b > best_l);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = val_q;
		rd_addr_a = parent;
		rd_addr_b = AW'(count_q);
		unique case (state_q)
			ST_UP_RD: begin
				// Root reached: drop the value into the hole.
				wr_en = (idx_q == '0);
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (rd_data_a < val_q) begin
					wr_data = rd_data_a;
				end
			end
			ST_DN_WAIT: begin
				rd_addr_a = '0;
			end
			ST_DN_RD: begin
				rd_addr_a = AW'(left_w);
				rd_addr_b = AW'(right_w);
				wr_en     = !left_ok;
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (pick_r) begin
					wr_data = rd_data_b;
				end else if (pick_l) begin
					wr_data = rd_data_a;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			val_q       <= '0;
			max_q       <= '0;
			status_q    <= mhpq_pkg::STATUS_OK;
		end else begin
			// Load a finished item, or drop the one the receiver took.
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						max_q    <= '0;
						status_q <= mhpq_pkg::STATUS_OK;
						val_q    <= req.value;
						if (req.action == mhpq_pkg::ACTION_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								status_q <= mhpq_pkg::STATUS_FULL;
								state_q  <= ST_DONE;
							end else begin
								idx_q   <= AW'(count_q);
								count_q <= count_q + CW'(1);
								state_q <= ST_UP_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= mhpq_pkg::STATUS_EMPTY;
								state_q  <= ST_DONE;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= ST_DN_WAIT;
							end
						end
					end
				end
				ST_UP_RD: begin
					state_q <= (idx_q == '0) ? ST_DONE : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					// Parent smaller: pull it down and climb.
					if (rd_data_a < val_q) begin
						idx_q   <= parent;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DN_WAIT: begin
					state_q <= ST_DN_LOAD;
				end
				ST_DN_LOAD: begin
					// Root is the result; the last entry starts at the root.
					max_q   <= rd_data_a;
					val_q   <= rd_data_b;
					idx_q   <= '0;
					state_q <= (count_q == '0) ? ST_DONE : ST_DN_RD;
				end
				ST_DN_RD: begin
					state_q <= left_ok ? ST_DN_CMP : ST_DONE;
				end
				ST_DN_CMP: begin
					if (pick_r) begin
						idx_q   <= AW'(right_w);
						state_q <= ST_DN_RD;
					end else if (pick_l) begin
						idx_q   <= AW'(left_w);
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register can take the item.
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.max_value <= max_q;
			rsp_q.status    <= status_q;
			rsp_q.entries   <= 6'(count_q);
		end
	end

endmodule
